@@ rtl/core/eske_pkg.sv @@
`default_nettype none
package eske_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 48;
    localparam int WORD_BITS      = 32;
    localparam int NUM_BITS       = 48;
    localparam int WIDTH_BITS     = 20;
    localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_US = 20'd1000000 - 20'd1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_KALMAN_Q      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KALMAN_R      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KALMAN_P_INIT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPEED_INIT    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPEED_NUM     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAS_DIV,
        ST_GAIN_DIV,
        ST_UPDATE,
        ST_COVAR,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic div_start_meas;
        logic div_start_gain;
        logic do_update;
        logic do_covar;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic div_done;
    } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/core/eske_divider.sv @@
`default_nettype none
module eske_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [63:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);
    import eske_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[63:0], quo_reg[63]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

@@ rtl/core/eske_datapath.sv @@
`default_nettype none
module eske_datapath #(
    parameter int FRACTION_BITS = 16,
    parameter int TIME_BITS     = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [eske_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [eske_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                 pin_level,
    input  wire logic [63:0]                          timestamp_us,
    input  wire eske_pkg::dp_cmd_t                    cmd,
    output eske_pkg::dp_status_t                      status,
    output logic [31:0]                               speed_estimate,
    output logic [31:0]                               pulse_total,
    output logic [19:0]                               pulse_width_us,
    output logic                                      edge_accepted
);
    import eske_pkg::*;

    localparam logic [63:0] ONE = 64'd1 << FRACTION_BITS;

    logic [31:0] q_reg, r_reg, p_init_reg, x_init_reg;
    logic [47:0] num_reg;
    logic                 prev_level_reg;
    logic [TIME_BITS-1:0] prev_time_reg;
    logic [31:0] p_reg, p_next, x_reg, x_next;
    logic [31:0] count_reg;
    logic [19:0] width_reg;
    logic [TIME_BITS-1:0] now_reg, intv_reg;
    logic        change_reg, level_reg;
    logic [31:0] meas_reg, pp_reg;
    logic [32:0] den_reg;
    logic [FRACTION_BITS:0] k_reg;
    logic        acc_reg;

    logic [TIME_BITS-1:0] now_w, intv_w;
    logic        div_start, div_done;
    logic [63:0] div_a, div_b, div_q;
    logic [32:0] p_sum;
    logic [31:0] diff;
    logic [FRACTION_BITS:0] rest_gain;
    logic [63:0] prod;
    logic [63:0] cprod;

    assign now_w     = timestamp_us[TIME_BITS-1:0];
    assign intv_w    = now_w - prev_time_reg;
    assign p_sum     = {1'b0, p_reg} + {1'b0, q_reg};
    assign diff      = (meas_reg >= x_reg) ? meas_reg - x_reg : x_reg - meas_reg;
    assign rest_gain = ONE[FRACTION_BITS:0] - k_reg;
    assign prod      = 64'(k_reg) * 64'(diff);
    assign cprod     = 64'(pp_reg) * 64'(rest_gain);

    assign div_start = cmd.div_start_meas | cmd.div_start_gain;
    assign div_a = cmd.div_start_meas ? {16'd0, num_reg} : (64'(pp_reg) << FRACTION_BITS);
    assign div_b = cmd.div_start_meas ? 64'(intv_reg) : 64'(den_reg);

    eske_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign status.div_done = div_done;
    assign status.edge_ok  = change_reg && level_reg && (intv_reg != '0)
                           && (intv_reg <= TIME_BITS'(MAX_WIDTH_US));

    always_comb
    begin
        p_next = p_reg;
        x_next = x_reg;
        if (cmd.do_update)
        begin
            if (meas_reg >= x_reg)
                x_next = x_reg + prod[FRACTION_BITS+31:FRACTION_BITS];
            else
                x_next = x_reg - prod[FRACTION_BITS+31:FRACTION_BITS];
        end
        if (cmd.do_covar)
            p_next = cprod[FRACTION_BITS+31:FRACTION_BITS];
        if (cfg_write && cfg_index == REG_KALMAN_P_INIT)
            p_next = cfg_data[31:0];
        if (cfg_write && cfg_index == REG_SPEED_INIT)
            x_next = cfg_data[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg          <= 32'd655;
            r_reg          <= 32'd65536;
            p_init_reg     <= 32'd65536;
            x_init_reg     <= '0;
            num_reg        <= '0;
            prev_level_reg <= 1'b0;
            prev_time_reg  <= '0;
            p_reg          <= 32'd65536;
            x_reg          <= '0;
            count_reg      <= '0;
            width_reg      <= '0;
            acc_reg        <= 1'b0;
        end
        else
        begin
            p_reg <= p_next;
            x_reg <= x_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_KALMAN_Q:      q_reg      <= cfg_data[31:0];
                    REG_KALMAN_R:      r_reg      <= cfg_data[31:0];
                    REG_KALMAN_P_INIT: p_init_reg <= cfg_data[31:0];
                    REG_SPEED_INIT:    x_init_reg <= cfg_data[31:0];
                    REG_SPEED_NUM:     num_reg    <= cfg_data[47:0];
                    default: ;
                endcase
            end
            if (cmd.capture)
            begin
                prev_level_reg <= pin_level;
                if (pin_level != prev_level_reg)
                    prev_time_reg <= now_w;
                acc_reg <= 1'b0;
            end
            if (cmd.div_start_meas)
            begin
                width_reg <= intv_reg[19:0];
                count_reg <= count_reg + 32'd1;
                acc_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg    <= now_w;
            intv_reg   <= intv_w;
            change_reg <= pin_level != prev_level_reg;
            level_reg  <= pin_level;
        end
        if (cmd.div_start_gain)
        begin
            meas_reg <= (div_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_q[31:0];
        end
        if (cmd.div_start_meas)
        begin
            pp_reg  <= p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
            den_reg <= {1'b0, (p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0])} + {1'b0, r_reg};
        end
        if (cmd.do_update)
            ;
        if (cmd.finish)
            ;
    end

    always_ff @(posedge clk)
    begin
        if (div_done && !cmd.div_start_gain && !cmd.div_start_meas && den_reg != '0)
            k_reg <= div_q[FRACTION_BITS:0];
        else if (cmd.div_start_gain && den_reg == '0)
            k_reg <= '0;
    end

    assign speed_estimate = x_reg;
    assign pulse_total    = count_reg;
    assign pulse_width_us = width_reg;
    assign edge_accepted  = acc_reg;

    logic unused;
    assign unused = ^{now_reg, p_init_reg, x_init_reg};
endmodule
`default_nettype wire

@@ rtl/core/eske_controller.sv @@
`default_nettype none
module eske_controller (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output eske_pkg::dp_cmd_t          cmd,
    input  wire eske_pkg::dp_status_t  status
);
    import eske_pkg::*;

    state_t state_reg, state_next;
    logic   gain_wait_reg, gain_wait_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_wait_reg <= gain_wait_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        gain_wait_next = gain_wait_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MEAS_DIV;
                    gain_wait_next = 1'b0;
                end
            end
            ST_MEAS_DIV:
            begin
                if (!gain_wait_next && !gain_wait_reg)
                begin
                    if (status.edge_ok)
                    begin
                        cmd.div_start_meas = 1'b1;
                        gain_wait_next     = 1'b1;
                    end
                    else
                        state_next = ST_OUTPUT;
                end
                else if (status.div_done)
                begin
                    cmd.div_start_gain = 1'b1;
                    gain_wait_next     = 1'b0;
                    state_next         = ST_GAIN_DIV;
                end
            end
            ST_GAIN_DIV:
            begin
                if (status.div_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.do_update = 1'b1;
                state_next    = ST_COVAR;
            end
            ST_COVAR:
            begin
                cmd.do_covar = 1'b1;
                state_next   = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/core/encoder_speed_kalman_estimator.sv @@
`default_nettype none
// Encoder speed estimator with a scalar Kalman filter in unsigned fixed point.
// The input channel carries one word per pin sample: pin_level and timestamp_us.
// The output channel returns one word per sample: speed_estimate, pulse_total,
// pulse_width_us and edge_accepted.
// Configuration registers are written through cfg_write, cfg_index, cfg_data;
// the user must write them only while the block is idle, which the block does
// not enforce. Writing kalman_p_init or speed_init also reloads the filter state.
// A sample without an accepted rising edge goes from idle through the
// measurement state to the output state. For an accepted edge, the single
// restoring divider computes the measurement and then the gain, followed by
// the estimate and covariance updates, and the next sample can be taken in
// the cycle after the result leaves the output.
// One sample is handled at a time; a stalled output holds its word and the
// input stays stalled until it is taken.
// Reset clears the edge history and count and restores register defaults.
module encoder_speed_kalman_estimator #(
    parameter int FRACTION_BITS = 16,
    parameter int TIME_BITS     = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        pin_level,
    input  wire logic [63:0] timestamp_us,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      speed_estimate,
    output logic [31:0]      pulse_total,
    output logic [19:0]      pulse_width_us,
    output logic             edge_accepted
);
    import eske_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    eske_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    eske_datapath #(
        .FRACTION_BITS (FRACTION_BITS),
        .TIME_BITS     (TIME_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pin_level      (pin_level),
        .timestamp_us   (timestamp_us),
        .cmd            (cmd),
        .status         (status),
        .speed_estimate (speed_estimate),
        .pulse_total    (pulse_total),
        .pulse_width_us (pulse_width_us),
        .edge_accepted  (edge_accepted)
    );
endmodule
`default_nettype wire
